// ----- hw/rtl/gcmp_pkg.sv -----
`timescale 1ns / 1ps

package gcmp_pkg;

  localparam int MAX_ROWS  = 1024;
  localparam int MAX_COLS  = 1024;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int SCORE_W   = 10;
  localparam int SCORE_CAP = (MAX_COLS - 1) < 1023 ? (MAX_COLS - 1) : 1023;
  localparam int CFG_W     = 11;
  localparam int KIND_W    = 3;
  localparam int ENTRY_W   = SCORE_W + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_EMPTY = 3'd0,
    KIND_WALL  = 3'd1,
    KIND_BONUS = 3'd2,
    KIND_EXIT  = 3'd3,
    KIND_START = 3'd4
  } cell_kind_t;

  typedef struct packed {
    logic               reach;
    logic [SCORE_W-1:0] score;
  } entry_t;

endpackage

// ----- hw/rtl/grid_column_max_path_dp.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Word contents
// s_axis    in         tdata[2:0] cell_kind, tlast last_cell
// m_axis    out        tdata[10:0] best_score (signed)
// cfg       in         cfg_data[10:0] row_count
//
// One cell is taken per cycle while the input is not stalled; each cell passes through the memory read
// and then the compute stage, which writes its entry back to the column memory.
// The result of a last cell is registered and appears in the cycle after the cell's compute stage.
// Reset sets row_count to 1024 and starts a fresh grid; no clearing pass is run.
// Only a last cell meeting a full, unread output register stalls the input.

module grid_column_max_path_dp
  import gcmp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [2:0] cell_kind
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [10:0] best_score
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [ROW_W-1:0]   last_row;
  logic [ROW_W-1:0]   row_pos;
  logic               first_col;

  logic               s2_valid;
  logic [KIND_W-1:0]  s2_kind;
  logic               s2_last;
  logic [ROW_W-1:0]   s2_pos;
  logic               s2_first;
  logic               s2_lastrow;
  logic               s2_fwd;
  entry_t             fwd_entry;

  entry_t             up_reg;
  entry_t             mid_reg;
  logic [SCORE_W-1:0] exit_best;
  logic               exit_seen;
  logic               out_valid;
  logic [CFG_W-1:0]   out_score;

  logic               in_fire;
  logic               cfg_fire;
  logic               s2_done;
  logic               pos_lastrow;
  logic [ROW_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_raw;
  entry_t             rd_fwd;
  entry_t             up_nb;
  entry_t             mid_nb;
  entry_t             down_nb;
  entry_t             entry;
  logic               reach;
  logic [SCORE_W-1:0] score;
  logic               exit_seen_next;
  logic [SCORE_W-1:0] exit_best_next;
  logic [ROW_W-1:0]   last_row_next;

  assign cfg_ready     = 1'b1;
  assign cfg_fire      = cfg_valid & cfg_ready;
  assign s2_done       = s2_valid & (~s2_last | ~out_valid | m_axis_tready);
  assign s_axis_tready = ~s2_valid | s2_done;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign pos_lastrow   = (row_pos == last_row);
  assign rd_addr       = pos_lastrow ? '0 : row_pos + 1'b1;

  gcmp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ROWS)
  ) u_column (
    .clk     (clk),
    .wr_en   (s2_done),
    .wr_addr (s2_pos),
    .wr_data (entry),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  always_comb begin
    rd_fwd  = s2_fwd ? fwd_entry : entry_t'(rd_raw);
    up_nb   = (s2_first || s2_pos == '0) ? '0 : up_reg;
    mid_nb  = s2_first ? '0 : mid_reg;
    down_nb = (s2_first || s2_lastrow) ? '0 : rd_fwd;

    reach = up_nb.reach | mid_nb.reach | down_nb.reach;
    score = '0;
    if (up_nb.reach && up_nb.score > score) begin
      score = up_nb.score;
    end
    if (mid_nb.reach && mid_nb.score > score) begin
      score = mid_nb.score;
    end
    if (down_nb.reach && down_nb.score > score) begin
      score = down_nb.score;
    end
    if (s2_kind == KIND_START) begin
      reach = 1'b1;
    end
    if (s2_kind == KIND_WALL) begin
      reach = 1'b0;
    end
    if (!reach) begin
      score = '0;
    end
    if (reach && s2_kind == KIND_BONUS && score < SCORE_W'(SCORE_CAP)) begin
      score = score + 1'b1;
    end
    entry.reach = reach;
    entry.score = score;

    exit_seen_next = exit_seen;
    exit_best_next = exit_best;
    if (reach && s2_kind == KIND_EXIT) begin
      exit_seen_next = 1'b1;
      if (score > exit_best) begin
        exit_best_next = score;
      end
    end
  end

  always_comb begin
    if (cfg_data == '0) begin
      last_row_next = '0;
    end else if (cfg_data > CFG_W'(MAX_ROWS)) begin
      last_row_next = ROW_W'(MAX_ROWS - 1);
    end else begin
      last_row_next = ROW_W'(cfg_data - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_row  <= ROW_W'(MAX_ROWS - 1);
      row_pos   <= '0;
      first_col <= 1'b1;
      s2_valid  <= 1'b0;
      exit_best <= '0;
      exit_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_fire) begin
        last_row  <= last_row_next;
        row_pos   <= '0;
        first_col <= 1'b1;
        exit_best <= '0;
        exit_seen <= 1'b0;
      end else begin
        if (in_fire) begin
          if (s_axis_tlast) begin
            row_pos   <= '0;
            first_col <= 1'b1;
          end else if (pos_lastrow) begin
            row_pos   <= '0;
            first_col <= 1'b0;
          end else begin
            row_pos <= row_pos + 1'b1;
          end
        end
        if (s2_done) begin
          if (s2_last) begin
            exit_best <= '0;
            exit_seen <= 1'b0;
          end else begin
            exit_best <= exit_best_next;
            exit_seen <= exit_seen_next;
          end
        end
      end

      if (in_fire) begin
        s2_valid <= 1'b1;
      end else if (s2_done) begin
        s2_valid <= 1'b0;
      end

      if (s2_done && s2_last) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s2_kind    <= s_axis_tdata[KIND_W-1:0];
      s2_last    <= s_axis_tlast;
      s2_pos     <= row_pos;
      s2_first   <= first_col;
      s2_lastrow <= pos_lastrow;
      s2_fwd     <= s2_valid && (rd_addr == s2_pos);
      fwd_entry  <= entry;
    end
    if (s2_done) begin
      up_reg <= mid_reg;
      if (s2_lastrow && s2_pos == '0) begin
        mid_reg <= entry;
      end else begin
        mid_reg <= rd_fwd;
      end
    end
    if (s2_done && s2_last) begin
      out_score <= exit_seen_next ? {1'b0, exit_best_next} : '1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(16 - CFG_W){1'b0}}, out_score};

endmodule

// ----- hw/rtl/gcmp_ram.sv -----
`timescale 1ns / 1ps

module gcmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- dv/grid_column_max_path_dp_test.sv -----
`timescale 1ns / 1ps

module grid_column_max_path_dp_test;
  import gcmp_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = KIND_W'(KIND_START + 1);
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = '1;
  localparam logic [ENTRY_W-1:0] NO_EXIT_SCORE   = '1;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  // Model of the grid state, kept in step with every accepted word.
  entry_t col_mem [MAX_ROWS];
  entry_t above_entry;
  int unsigned row_pos;
  logic [SCORE_W-1:0] exit_best;
  bit exit_seen;
  logic [CFG_W-1:0] row_count_q;

  logic [ENTRY_W-1:0] predicted_scores [$];
  bit failed;
  bit source_gap_on;
  bit sink_stall_on;
  int sink_hold;
  int idle_cycles;

  grid_column_max_path_dp i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_grid();
    foreach (col_mem[i]) col_mem[i] = '0;
    above_entry = '0;
    row_pos = 0;
    exit_best = '0;
    exit_seen = 1'b0;
  endfunction

  function automatic int unsigned active_rows();
    if (row_count_q == 0) return 1;
    if (row_count_q > MAX_ROWS) return MAX_ROWS;
    return row_count_q;
  endfunction

  function automatic void predict_cell(input logic [KIND_W-1:0] kind, input logic last);
    int unsigned rows;
    logic [ROW_W-1:0] p;
    entry_t nb [3];
    logic [SCORE_W-1:0] best;
    logic reach;
    rows = active_rows();
    p = (row_pos >= rows) ? ROW_W'(rows - 1) : ROW_W'(row_pos);
    nb[0] = (p > 0) ? above_entry : '0;
    nb[1] = col_mem[p];
    nb[2] = (p + 1 < rows) ? col_mem[p + 1'b1] : '0;
    best = '0;
    reach = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (nb[i].reach) begin
        reach = 1'b1;
        if (nb[i].score > best) best = nb[i].score;
      end
    end
    if (kind == KIND_START) reach = 1'b1;
    if (kind == KIND_WALL) reach = 1'b0;
    if (!reach) best = '0;
    if (reach && kind == KIND_BONUS && best < SCORE_CAP) best++;
    col_mem[p] = reach ? {1'b1, best} : '0;
    above_entry = nb[1];
    if (reach && kind == KIND_EXIT) begin
      exit_seen = 1'b1;
      if (best > exit_best) exit_best = best;
    end
    row_pos = (p + 1 >= rows) ? 0 : p + 1;
    if (last) begin
      predicted_scores.push_back(exit_seen ? {1'b0, exit_best} : NO_EXIT_SCORE);
      clear_grid();
    end
  endfunction

  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int source_gap();
    if (!source_gap_on || $urandom_range(0, 3) != 0) return 0;
    return idle_length();
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return KIND_EMPTY;
    if (r < 55) return KIND_WALL;
    if (r < 80) return KIND_BONUS;
    if (r < 90) return KIND_EXIT;
    if (r < 97) return KIND_START;
    return KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
  endfunction

  // Called and returning at a falling edge.
  task automatic send_cell(input logic [KIND_W-1:0] kind, input logic last);
    int gap;
    gap = source_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, kind};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    predict_cell(kind, last);
    @(negedge clk);
  endtask

  // Holds the sender until every expected word has arrived and the pipeline is empty.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (predicted_scores.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_row_count(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    row_count_q = value;
    clear_grid();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_cell(KIND_START, 1'b0);
    send_cell(KIND_EXIT, 1'b0);
    send_cell(KIND_BONUS, 1'b1);
    send_cell(KIND_START, 1'b1);
  endtask

  task automatic test_edge_rows();
    write_row_count(3);
    send_cell(KIND_START, 1'b0);
    send_cell(KIND_EMPTY, 1'b0);
    send_cell(KIND_START, 1'b0);
    send_cell(KIND_BONUS, 1'b0);
    send_cell(KIND_WALL, 1'b0);
    send_cell(KIND_BONUS, 1'b0);
    send_cell(KIND_SPARE_FIRST, 1'b0);
    send_cell(KIND_START, 1'b0);
    send_cell(KIND_SPARE_LAST, 1'b0);
    send_cell(KIND_EXIT, 1'b0);
    send_cell(KIND_BONUS, 1'b0);
    send_cell(KIND_W'(KIND_SPARE_FIRST + 1), 1'b0);
    send_cell(KIND_EMPTY, 1'b0);
    send_cell(KIND_EXIT, 1'b0);
    send_cell(KIND_EXIT, 1'b1);
  endtask

  task automatic test_grid_ends();
    write_row_count(2);
    send_cell(KIND_WALL, 1'b0);
    send_cell(KIND_WALL, 1'b0);
    send_cell(KIND_EXIT, 1'b0);
    send_cell(KIND_EXIT, 1'b1);
    send_cell(KIND_START, 1'b0);
    send_cell(KIND_EMPTY, 1'b0);
    send_cell(KIND_EXIT, 1'b1);
    send_cell(KIND_EXIT, 1'b0);
    send_cell(KIND_EMPTY, 1'b0);
    send_cell(KIND_EXIT, 1'b0);
    send_cell(KIND_BONUS, 1'b1);
  endtask

  task automatic test_config_midgrid();
    write_row_count(4);
    for (int i = 0; i < 6; i++) send_cell(i % 2 ? KIND_BONUS : KIND_START, 1'b0);
    write_row_count(4);
    send_cell(KIND_EMPTY, 1'b0);
    send_cell(KIND_EXIT, 1'b0);
    send_cell(KIND_EMPTY, 1'b0);
    send_cell(KIND_EMPTY, 1'b0);
    for (int i = 0; i < 4; i++) send_cell(KIND_EXIT, i == 3);
  endtask

  task automatic test_row_count_extremes();
    write_row_count(0);
    send_cell(KIND_START, 1'b0);
    send_cell(KIND_BONUS, 1'b0);
    send_cell(KIND_EXIT, 1'b1);
    write_row_count(1);
    send_cell(KIND_START, 1'b0);
    send_cell(KIND_WALL, 1'b0);
    send_cell(KIND_EXIT, 1'b1);
    write_row_count(2047);
    for (int i = 0; i < MAX_ROWS + 4; i++) send_cell(pick_kind(), i == MAX_ROWS + 3);
    write_row_count(1024);
    send_cell(KIND_START, 1'b0);
    send_cell(KIND_EXIT, 1'b1);
  endtask

  task automatic test_score_saturation();
    write_row_count(0);
    send_cell(KIND_START, 1'b0);
    for (int i = 0; i < SCORE_CAP + 6; i++) send_cell(KIND_BONUS, 1'b0);
    send_cell(KIND_EXIT, 1'b1);
  endtask

  task automatic test_random();
    int unsigned items;
    int unsigned grids;
    int unsigned cells;
    int r;
    items = 0;
    grids = 0;
    while (items < 750 || grids < 40) begin
      if (grids == 0 || $urandom_range(0, 9) < 3) begin
        r = $urandom_range(0, 99);
        if (r < 70) write_row_count(CFG_W'($urandom_range(1, 6)));
        else if (r < 95) write_row_count(CFG_W'($urandom_range(7, 40)));
        else write_row_count(0);
      end
      source_gap_on = ($urandom_range(0, 4) != 0);
      sink_stall_on = ($urandom_range(0, 4) != 0);
      cells = active_rows() * $urandom_range(1, 8);
      // Some grids are cut short so that they can end part-way through a column.
      if ($urandom_range(0, 9) == 0) cells = $urandom_range(1, cells);
      for (int unsigned c = 0; c < cells; c++) send_cell(pick_kind(), c == cells - 1);
      items += cells;
      grids++;
      if ($urandom_range(0, 6) == 0) drain_results();
    end
    source_gap_on = 1'b1;
    sink_stall_on = 1'b1;
  endtask

  initial begin
    m_axis_tready = 1'b0;
    sink_hold = 0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (sink_stall_on && $urandom_range(0, 7) == 0) begin
        sink_hold = idle_length() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (predicted_scores.size() == 0) begin
        $display("%0t: best_score word %0d arrived with none expected", $time,
                 $signed(m_axis_tdata[ENTRY_W-1:0]));
        failed = 1'b1;
      end else if (m_axis_tdata[ENTRY_W-1:0] !== predicted_scores[0]) begin
        $display("%0t: best_score mismatch, expected %0d, actual %0d", $time,
                 $signed(predicted_scores[0]), $signed(m_axis_tdata[ENTRY_W-1:0]));
        failed = 1'b1;
        void'(predicted_scores.pop_front());
      end else begin
        void'(predicted_scores.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    failed = 1'b0;
    idle_cycles = 0;
    source_gap_on = 1'b1;
    sink_stall_on = 1'b1;
    row_count_q = CFG_W'(MAX_ROWS);
    clear_grid();
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_edge_rows();
    test_grid_ends();
    test_config_midgrid();
    test_row_count_extremes();
    test_score_saturation();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (predicted_scores.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/gcmp_pkg.sv
hw/rtl/gcmp_ram.sv
hw/rtl/grid_column_max_path_dp.sv
dv/grid_column_max_path_dp_test.sv
